@@ rtl/gimbal_relative_mecanum_drive_top_assert.svh @@
// Assertion macros for the gimbal relative mecanum drive block.
// Used by gimbal_relative_mecanum_drive_top; expects i_clk and i_rst_n in scope.
`ifndef GIMBAL_RELATIVE_MECANUM_DRIVE_TOP_ASSERT_SVH
`define GIMBAL_RELATIVE_MECANUM_DRIVE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GRMD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("grmd assertion failed");
`define GRMD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("grmd assertion failed");
`else
`define GRMD_ASSERT_IMP(lbl, ante, cons)
`define GRMD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/grmd_pkg.sv @@
// Package for the gimbal relative mecanum drive block: widths, constants,
// register codes and the sine polynomial, saturation and ramp functions.
// No dependencies.
package grmd_pkg;

    localparam int ANGLE_BITS   = 13;
    localparam int ANGLE_COUNTS = 1 << ANGLE_BITS;
    localparam int HALF_TURN    = ANGLE_COUNTS / 2;
    localparam int PHASE_BITS   = 16;
    localparam int PHASE_SHIFT  = PHASE_BITS - ANGLE_BITS;
    localparam int QUARTER      = 16384;

    localparam int LOCK_DEAD    = (111 * ANGLE_COUNTS) / 8192;
    localparam int LOCK_STEEP   = (660 * ANGLE_COUNTS) / 8192;
    localparam int GAIN_LOW     = 7200;
    localparam int GAIN_HIGH    = 14400;

    localparam int SIN_A        = 51472;
    localparam int SIN_B        = 21024;
    localparam int SIN_C        = 2320;
    localparam int Q15_MAX      = 32767;
    localparam int ROUND_HALF   = 16384;

    localparam int CMD_W        = 15;
    localparam int WHEEL_W      = 16;
    localparam int STEP_W       = 13;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_MID_YAW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 2'd1;

    localparam logic [ANGLE_BITS-1:0] MID_YAW_RST   = 13'd0;
    localparam logic [STEP_W-1:0]     RAMP_STEP_RST = 13'd20;

    typedef logic signed [WHEEL_W-1:0] t_wheel;
    typedef logic signed [CMD_W-1:0]   t_cmd;

    // quarter-wave position times two, Q15
    function automatic logic [15:0] fold_z(logic [PHASE_BITS-1:0] phase);
        logic [13:0] xq;
        logic [14:0] q;
        xq = phase[13:0];
        q  = phase[14] ? (15'(QUARTER) - {1'b0, xq}) : {1'b0, xq};
        return {q, 1'b0};
    endfunction

    function automatic logic [15:0] square_q15(logic [15:0] z);
        logic [31:0] p;
        p = 32'(z) * 32'(z);
        return 16'(p >> 15);
    endfunction

    function automatic logic [11:0] poly_t1(logic [15:0] z2);
        logic [31:0] p;
        p = 32'(SIN_C) * 32'(z2);
        return 12'(p >> 15);
    endfunction

    function automatic logic [14:0] poly_t2(logic [15:0] z2, logic [11:0] t1);
        logic [31:0] p;
        p = (32'(SIN_B) - 32'(t1)) * 32'(z2);
        return 15'(p >> 15);
    endfunction

    function automatic logic signed [15:0] poly_out(logic [15:0] z, logic [14:0] t2,
                                                   logic neg);
        logic [31:0] p;
        logic [16:0] m;
        logic [14:0] c;
        p = (32'(SIN_A) - 32'(t2)) * 32'(z);
        m = 17'(p >> 15);
        c = (m > 17'(Q15_MAX)) ? 15'(Q15_MAX) : m[14:0];
        return neg ? -$signed({1'b0, c}) : $signed({1'b0, c});
    endfunction

    function automatic t_wheel sat16(logic signed [18:0] v);
        if (v > 19'sd32767) begin
            return 16'sh7fff;
        end else if (v < -19'sd32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    function automatic t_wheel ramp_to(t_wheel tgt, t_wheel cur, logic [STEP_W-1:0] step);
        logic signed [17:0] diff;
        logic signed [17:0] up;
        logic signed [17:0] dn;
        diff = 18'(tgt) - 18'(cur);
        up   = 18'(cur) + $signed({5'b0, step});
        dn   = 18'(cur) - $signed({5'b0, step});
        if (diff >= 18'sd0) begin
            return (up > 18'(tgt)) ? tgt : 16'(up);
        end
        return (dn < 18'(tgt)) ? tgt : 16'(dn);
    endfunction

    function automatic logic ramp_bounded(t_wheel nv, t_wheel ov, logic [STEP_W-1:0] step);
        logic signed [16:0] diff;
        logic [16:0]        mag;
        diff = 17'(nv) - 17'(ov);
        mag  = (diff < 17'sd0) ? 17'(-diff) : 17'(diff);
        return mag <= 17'(step);
    endfunction

endpackage

@@ rtl/gimbal_relative_mecanum_drive_top.sv @@
// Gimbal relative mecanum drive: rotate, lock-correct, mix and ramp wheel targets.
// Depends on grmd_pkg and gimbal_relative_mecanum_drive_top_assert.svh.
//
// One command word per clock is taken while the output is not stalled; each word
// runs through a nine-register pipeline (input register, seven compute stages,
// result register) on its way to the wheel word. Depth is set by the quarter-wave
// sine polynomial, one multiply per stage, followed by the rotation products,
// rounding, mix and ramp. The output register holds the wheel setpoints;
// a stalled output backs up the pipeline one stage at a time, and empty stages
// still take new words. Configuration writes are registered and always ready
// out of reset.
`include "gimbal_relative_mecanum_drive_top_assert.svh"

module gimbal_relative_mecanum_drive_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [grmd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [grmd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [grmd_pkg::CMD_W-1:0]    i_cmd_x,
    input  logic signed [grmd_pkg::CMD_W-1:0]    i_cmd_y,
    input  logic signed [grmd_pkg::CMD_W-1:0]    i_cmd_z,
    input  logic [grmd_pkg::ANGLE_BITS-1:0]      i_yaw_angle,
    input  logic                                 i_mode,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [grmd_pkg::WHEEL_W-1:0]  o_wheel_a,
    output logic signed [grmd_pkg::WHEEL_W-1:0]  o_wheel_b,
    output logic signed [grmd_pkg::WHEEL_W-1:0]  o_wheel_c,
    output logic signed [grmd_pkg::WHEEL_W-1:0]  o_wheel_d
);

    localparam int NUM_STG = 8;

    logic [grmd_pkg::ANGLE_BITS-1:0] r_mid_yaw;
    logic [grmd_pkg::STEP_W-1:0]     r_ramp_step;

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] w_en;
    logic               r_out_vld;
    logic               w_out_en;
    logic               w_ld_out;

    // stage 0: input register
    grmd_pkg::t_cmd                  r0_x, r0_y, r0_z;
    logic [grmd_pkg::ANGLE_BITS-1:0] r0_yaw;
    logic                            r0_mode;

    // stage 1
    grmd_pkg::t_cmd       r1_x, r1_y;
    logic signed [15:0]   r1_z;
    logic [15:0]          r1_zs, r1_zc, r1_z2s, r1_z2c;
    logic                 r1_neg_s, r1_neg_c;

    // stage 2
    grmd_pkg::t_cmd       r2_x, r2_y;
    logic signed [15:0]   r2_z;
    logic [15:0]          r2_zs, r2_zc, r2_z2s, r2_z2c;
    logic [11:0]          r2_t1s, r2_t1c;
    logic                 r2_neg_s, r2_neg_c;

    // stage 3
    grmd_pkg::t_cmd       r3_x, r3_y;
    logic signed [15:0]   r3_z;
    logic [15:0]          r3_zs, r3_zc;
    logic [14:0]          r3_t2s, r3_t2c;
    logic                 r3_neg_s, r3_neg_c;

    // stage 4
    grmd_pkg::t_cmd       r4_x, r4_y;
    logic signed [15:0]   r4_z;
    logic signed [15:0]   r4_s, r4_c;

    // stage 5
    logic signed [30:0]   r5_xc, r5_ys, r5_xs, r5_yc;
    logic signed [15:0]   r5_z;

    // stage 6
    logic signed [16:0]   r6_rx, r6_ry;
    logic signed [15:0]   r6_z;

    // stage 7
    grmd_pkg::t_wheel [3:0] r7_tgt;

    // result register, also the wheel setpoint state
    grmd_pkg::t_wheel [3:0] r_wheel;

    // stage 1 combinational
    logic [grmd_pkg::ANGLE_BITS-1:0] w_d;
    logic [grmd_pkg::PHASE_BITS-1:0] w_ph_s, w_ph_c;
    logic [15:0]                     w_zs, w_zc;
    logic signed [14:0]              w_e_raw, w_e;
    logic [12:0]                     w_mag;
    logic [13:0]                     w_gain;
    logic [26:0]                     w_mprod;
    logic [12:0]                     w_m;
    logic signed [15:0]              w_z_lock;

    // stage 6/7 combinational
    logic signed [31:0]     w_sx, w_sy;
    logic signed [18:0]     w_rx, w_ry, w_z;
    logic signed [18:0]     w_sum [4];

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_yaw   <= grmd_pkg::MID_YAW_RST;
            r_ramp_step <= grmd_pkg::RAMP_STEP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                grmd_pkg::CFG_MID_YAW:   r_mid_yaw   <= i_cfg_data;
                grmd_pkg::CFG_RAMP_STEP: r_ramp_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or the next one advances
    always_comb begin
        w_out_en           = !r_out_vld || i_out_ready;
        w_en[NUM_STG-1]    = !r_vld[NUM_STG-1] || w_out_en;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready = w_en[0] && i_rst_n;
    assign w_ld_out   = w_out_en && r_vld[NUM_STG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_out_en) begin
                r_out_vld <= r_vld[NUM_STG-1];
            end
        end
    end

    always_comb begin
        w_d    = r0_yaw - r_mid_yaw;
        w_ph_s = grmd_pkg::PHASE_BITS'(w_d) << grmd_pkg::PHASE_SHIFT;
        w_ph_c = w_ph_s + grmd_pkg::PHASE_BITS'(grmd_pkg::QUARTER);
        w_zs   = grmd_pkg::fold_z(w_ph_s);
        w_zc   = grmd_pkg::fold_z(w_ph_c);

        w_e_raw = $signed({2'b00, r_mid_yaw}) - $signed({2'b00, r0_yaw});
        if (w_e_raw <= -15'(grmd_pkg::HALF_TURN)) begin
            w_e = w_e_raw + 15'(grmd_pkg::ANGLE_COUNTS);
        end else if (w_e_raw >= 15'(grmd_pkg::HALF_TURN)) begin
            w_e = w_e_raw - 15'(grmd_pkg::ANGLE_COUNTS);
        end else begin
            w_e = w_e_raw;
        end
        w_mag   = (w_e < 15'sd0) ? 13'(-w_e) : 13'(w_e);
        w_gain  = (w_mag < 13'(grmd_pkg::LOCK_STEEP)) ? 14'(grmd_pkg::GAIN_LOW)
                                                       : 14'(grmd_pkg::GAIN_HIGH);
        w_mprod = 27'(w_mag) * 27'(w_gain) + 27'(grmd_pkg::HALF_TURN);
        w_m     = 13'(w_mprod >> grmd_pkg::ANGLE_BITS);

        w_z_lock = 16'(r0_z);
        if (r0_mode && (w_mag >= 13'(grmd_pkg::LOCK_DEAD))) begin
            if (w_e < 15'sd0) begin
                w_z_lock = 16'(r0_z) + $signed({3'b000, w_m});
            end else begin
                w_z_lock = 16'(r0_z) - $signed({3'b000, w_m});
            end
        end
    end

    always_comb begin
        w_sx = 32'(r5_xc) - 32'(r5_ys) + 32'(grmd_pkg::ROUND_HALF);
        w_sy = 32'(r5_xs) + 32'(r5_yc) + 32'(grmd_pkg::ROUND_HALF);

        w_rx = 19'(r6_rx);
        w_ry = 19'(r6_ry);
        w_z  = 19'(r6_z);
        w_sum[0] =  w_rx + w_ry - w_z;
        w_sum[1] =  w_rx - w_ry - w_z;
        w_sum[2] = -w_rx - w_ry - w_z;
        w_sum[3] = -w_rx + w_ry - w_z;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_x    <= i_cmd_x;
            r0_y    <= i_cmd_y;
            r0_z    <= i_cmd_z;
            r0_yaw  <= i_yaw_angle;
            r0_mode <= i_mode;
        end
        if (w_en[1]) begin
            r1_x     <= r0_x;
            r1_y     <= r0_y;
            r1_z     <= w_z_lock;
            r1_zs    <= w_zs;
            r1_zc    <= w_zc;
            r1_z2s   <= grmd_pkg::square_q15(w_zs);
            r1_z2c   <= grmd_pkg::square_q15(w_zc);
            r1_neg_s <= w_ph_s[grmd_pkg::PHASE_BITS-1];
            r1_neg_c <= w_ph_c[grmd_pkg::PHASE_BITS-1];
        end
        if (w_en[2]) begin
            r2_x     <= r1_x;
            r2_y     <= r1_y;
            r2_z     <= r1_z;
            r2_zs    <= r1_zs;
            r2_zc    <= r1_zc;
            r2_z2s   <= r1_z2s;
            r2_z2c   <= r1_z2c;
            r2_t1s   <= grmd_pkg::poly_t1(r1_z2s);
            r2_t1c   <= grmd_pkg::poly_t1(r1_z2c);
            r2_neg_s <= r1_neg_s;
            r2_neg_c <= r1_neg_c;
        end
        if (w_en[3]) begin
            r3_x     <= r2_x;
            r3_y     <= r2_y;
            r3_z     <= r2_z;
            r3_zs    <= r2_zs;
            r3_zc    <= r2_zc;
            r3_t2s   <= grmd_pkg::poly_t2(r2_z2s, r2_t1s);
            r3_t2c   <= grmd_pkg::poly_t2(r2_z2c, r2_t1c);
            r3_neg_s <= r2_neg_s;
            r3_neg_c <= r2_neg_c;
        end
        if (w_en[4]) begin
            r4_x <= r3_x;
            r4_y <= r3_y;
            r4_z <= r3_z;
            r4_s <= grmd_pkg::poly_out(r3_zs, r3_t2s, r3_neg_s);
            r4_c <= grmd_pkg::poly_out(r3_zc, r3_t2c, r3_neg_c);
        end
        if (w_en[5]) begin
            r5_xc <= 31'(32'(r4_x) * 32'(r4_c));
            r5_ys <= 31'(32'(r4_y) * 32'(r4_s));
            r5_xs <= 31'(32'(r4_x) * 32'(r4_s));
            r5_yc <= 31'(32'(r4_y) * 32'(r4_c));
            r5_z  <= r4_z;
        end
        if (w_en[6]) begin
            r6_rx <= 17'(w_sx >>> 15);
            r6_ry <= 17'(w_sy >>> 15);
            r6_z  <= r5_z;
        end
        if (w_en[7]) begin
            for (int i = 0; i < 4; i++) begin
                r7_tgt[i] <= grmd_pkg::sat16(w_sum[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel <= '0;
        end else if (w_ld_out) begin
            for (int i = 0; i < 4; i++) begin
                r_wheel[i] <= grmd_pkg::ramp_to(r7_tgt[i], r_wheel[i], r_ramp_step);
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_wheel_a   = r_wheel[0];
    assign o_wheel_b   = r_wheel[1];
    assign o_wheel_c   = r_wheel[2];
    assign o_wheel_d   = r_wheel[3];

    `GRMD_ASSERT_NXT(a_ramp_bound, w_ld_out,
        grmd_pkg::ramp_bounded(r_wheel[0], $past(r_wheel[0]), $past(r_ramp_step)) &&
        grmd_pkg::ramp_bounded(r_wheel[1], $past(r_wheel[1]), $past(r_ramp_step)) &&
        grmd_pkg::ramp_bounded(r_wheel[2], $past(r_wheel[2]), $past(r_ramp_step)) &&
        grmd_pkg::ramp_bounded(r_wheel[3], $past(r_wheel[3]), $past(r_ramp_step)))
    `GRMD_ASSERT_NXT(a_hold_state, !w_ld_out, $stable(r_wheel))
    `GRMD_ASSERT_NXT(a_out_load, w_ld_out, r_out_vld)
    `GRMD_ASSERT_IMP(a_full_stall, (&r_vld) && r_out_vld && !i_out_ready, !o_in_ready)

endmodule
